// File: rtl/acs_pkg.sv
`timescale 1ns / 1ps
// Package for the alignment column statistics block: field widths, residue
// codes and the amino-acid class lookup. No dependencies.
package acs_pkg;

    localparam int RES_W     = 7;
    localparam int COL_GAP_W = 11;
    localparam int GAP_SUM_W = 27;
    localparam int COL_SUM_W = 17;

    localparam logic [RES_W-1:0] GAP_CODE  = 7'd46;
    localparam logic [RES_W-1:0] DASH_CODE = 7'd45;

    localparam logic [COL_GAP_W-1:0] COL_GAP_MAX = '1;
    localparam logic [GAP_SUM_W-1:0] GAP_SUM_MAX = '1;
    localparam logic [COL_SUM_W-1:0] COL_SUM_MAX = '1;

    typedef logic [RES_W-1:0] t_residue;

    // Maps a residue code to the representative code of its class.
    function automatic t_residue class_of(input t_residue r);
        t_residue c;
        case (r)
            t_residue'("I"), t_residue'("L"), t_residue'("A"),
            t_residue'("M"), t_residue'("G"): c = t_residue'("V");
            t_residue'("S"):                  c = t_residue'("T");
            t_residue'("D"):                  c = t_residue'("E");
            t_residue'("K"), t_residue'("H"): c = t_residue'("R");
            t_residue'("Q"):                  c = t_residue'("N");
            t_residue'("F"):                  c = t_residue'("Y");
            default:                          c = r;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/alignment_column_stats.sv
`timescale 1ns / 1ps
// Top level of the alignment column statistics block: per-column gap,
// conservation and similarity figures with running totals. Uses acs_pkg.
//
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_residue, i_column_end, i_alignment_end
// result    out        o_valid / i_ready    o_column_*, o_*_total, o_last
//
// One word is accepted per cycle; a result appears in the cycle after the word
// that closes its column. The column state and totals update in the cycle of
// acceptance, and the result sits in a single output register. The input
// stalls only while that register holds a result that is not being taken.
// Reset clears the column state, totals and output valid.
module alignment_column_stats (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [acs_pkg::RES_W-1:0]    i_residue,
    input  logic                         i_column_end,
    input  logic                         i_alignment_end,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [acs_pkg::COL_GAP_W-1:0] o_column_gap_count,
    output logic                         o_column_conserved,
    output logic                         o_column_similar,
    output logic [acs_pkg::GAP_SUM_W-1:0] o_gap_total,
    output logic [acs_pkg::COL_SUM_W-1:0] o_conserved_total,
    output logic [acs_pkg::COL_SUM_W-1:0] o_similar_total,
    output logic                         o_last
);
    import acs_pkg::*;

    logic                 r_at_start, n_at_start;
    t_residue             r_lead, n_lead;
    t_residue             r_lead_cls, n_lead_cls;
    logic                 r_all_same, n_all_same;
    logic                 r_all_alike, n_all_alike;
    logic [COL_GAP_W-1:0] r_col_gaps, n_col_gaps;
    logic [GAP_SUM_W-1:0] r_gap_sum, n_gap_sum;
    logic [COL_SUM_W-1:0] r_cons_sum, n_cons_sum;
    logic [COL_SUM_W-1:0] r_sim_sum, n_sim_sum;

    logic                 r_out_valid;
    logic [COL_GAP_W-1:0] r_out_col_gaps;
    logic                 r_out_cons;
    logic                 r_out_sim;
    logic [GAP_SUM_W-1:0] r_out_gap_sum;
    logic [COL_SUM_W-1:0] r_out_cons_sum;
    logic [COL_SUM_W-1:0] r_out_sim_sum;
    logic                 r_out_last;

    logic                 in_fire;
    logic                 closes;
    t_residue             res;
    t_residue             cls;
    t_residue             lead;
    t_residue             lead_cls;
    logic                 same;
    logic                 alike;
    logic                 is_gap;
    logic [COL_GAP_W-1:0] col_gaps;
    logic [GAP_SUM_W-1:0] gap_sum;
    logic                 cons;
    logic                 sim;
    logic [COL_SUM_W-1:0] cons_sum;
    logic [COL_SUM_W-1:0] sim_sum;

    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;
    assign closes  = i_column_end || i_alignment_end;

    always_comb begin
        res      = (i_residue == DASH_CODE) ? GAP_CODE : i_residue;
        cls      = class_of(res);
        lead     = r_at_start ? res : r_lead;
        lead_cls = r_at_start ? cls : r_lead_cls;
        same     = r_at_start || (r_all_same && (res == r_lead));
        alike    = r_at_start || (r_all_alike && (cls == r_lead_cls));
        is_gap   = (res == GAP_CODE);
        col_gaps = (is_gap && r_col_gaps != COL_GAP_MAX) ? r_col_gaps + 1'b1 : r_col_gaps;
        gap_sum  = (is_gap && r_gap_sum != GAP_SUM_MAX) ? r_gap_sum + 1'b1 : r_gap_sum;
        cons     = (lead != GAP_CODE) && same;
        sim      = (lead != GAP_CODE) && alike;
        cons_sum = (cons && r_cons_sum != COL_SUM_MAX) ? r_cons_sum + 1'b1 : r_cons_sum;
        sim_sum  = (sim && r_sim_sum != COL_SUM_MAX) ? r_sim_sum + 1'b1 : r_sim_sum;

        n_at_start  = r_at_start;
        n_lead      = r_lead;
        n_lead_cls  = r_lead_cls;
        n_all_same  = r_all_same;
        n_all_alike = r_all_alike;
        n_col_gaps  = r_col_gaps;
        n_gap_sum   = r_gap_sum;
        n_cons_sum  = r_cons_sum;
        n_sim_sum   = r_sim_sum;
        if (in_fire) begin
            if (closes) begin
                n_at_start  = 1'b1;
                n_lead      = '0;
                n_lead_cls  = '0;
                n_all_same  = 1'b1;
                n_all_alike = 1'b1;
                n_col_gaps  = '0;
                n_gap_sum   = i_alignment_end ? '0 : gap_sum;
                n_cons_sum  = i_alignment_end ? '0 : cons_sum;
                n_sim_sum   = i_alignment_end ? '0 : sim_sum;
            end else begin
                n_at_start  = 1'b0;
                n_lead      = lead;
                n_lead_cls  = lead_cls;
                n_all_same  = same;
                n_all_alike = alike;
                n_col_gaps  = col_gaps;
                n_gap_sum   = gap_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_lead      <= '0;
            r_lead_cls  <= '0;
            r_all_same  <= 1'b1;
            r_all_alike <= 1'b1;
            r_col_gaps  <= '0;
            r_gap_sum   <= '0;
            r_cons_sum  <= '0;
            r_sim_sum   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_at_start  <= n_at_start;
            r_lead      <= n_lead;
            r_lead_cls  <= n_lead_cls;
            r_all_same  <= n_all_same;
            r_all_alike <= n_all_alike;
            r_col_gaps  <= n_col_gaps;
            r_gap_sum   <= n_gap_sum;
            r_cons_sum  <= n_cons_sum;
            r_sim_sum   <= n_sim_sum;
            if (in_fire && closes) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && closes) begin
            r_out_col_gaps <= col_gaps;
            r_out_cons     <= cons;
            r_out_sim      <= sim;
            r_out_gap_sum  <= gap_sum;
            r_out_cons_sum <= cons_sum;
            r_out_sim_sum  <= sim_sum;
            r_out_last     <= i_alignment_end;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_column_gap_count = r_out_col_gaps;
    assign o_column_conserved = r_out_cons;
    assign o_column_similar   = r_out_sim;
    assign o_gap_total        = r_out_gap_sum;
    assign o_conserved_total  = r_out_cons_sum;
    assign o_similar_total    = r_out_sim_sum;
    assign o_last             = r_out_last;

endmodule

// File: rtl/acs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for alignment_column_stats, bound to the top level.
// Uses acs_pkg for field widths.
module acs_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic                         i_column_end,
    input  logic                         i_alignment_end,
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic [acs_pkg::COL_GAP_W-1:0] o_column_gap_count,
    input  logic                         o_column_conserved,
    input  logic                         o_column_similar,
    input  logic [acs_pkg::GAP_SUM_W-1:0] o_gap_total,
    input  logic [acs_pkg::COL_SUM_W-1:0] o_conserved_total,
    input  logic [acs_pkg::COL_SUM_W-1:0] o_similar_total,
    input  logic                         o_last
);
    import acs_pkg::*;

    // A stalled result holds its gap total and last flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_gap_total) && $stable(o_last))
        else $error("stalled result changed");

    // A word that closes no column produces no result.
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_column_end && !i_alignment_end && !o_valid |=> !o_valid)
        else $error("result without a column end");

    // Identical residues always share a class, so a conserved column is also similar.
    a_cons_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_column_conserved |-> o_column_similar && o_conserved_total != '0)
        else $error("conserved column not similar");

    // The gap total always includes the current column.
    a_gap_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {{(GAP_SUM_W-COL_GAP_W){1'b0}}, o_column_gap_count} <= o_gap_total)
        else $error("gap total below column gap count");

    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_conserved_total <= o_similar_total)
        else $error("conserved total exceeds similar total");

endmodule

bind alignment_column_stats acs_checker u_acs_checker (.*);

// File: sim/alignment_column_stats_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for alignment_column_stats: streams residue words,
// predicts every column result and compares it field by field. Uses acs_pkg.
module alignment_column_stats_tb;

    import acs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_WORDS = 650;

    typedef struct {
        logic [COL_GAP_W-1:0] gap_count;
        logic                 conserved;
        logic                 similar;
        logic [GAP_SUM_W-1:0] gap_total;
        logic [COL_SUM_W-1:0] conserved_total;
        logic [COL_SUM_W-1:0] similar_total;
        logic                 last;
    } t_column_result;

    typedef enum int {
        COL_CONSERVED,
        COL_SIMILAR,
        COL_RANDOM,
        COL_GAPPY
    } t_column_style;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [RES_W-1:0]     i_residue = '0;
    logic                 i_column_end = 1'b0;
    logic                 i_alignment_end = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [COL_GAP_W-1:0] o_column_gap_count;
    logic                 o_column_conserved;
    logic                 o_column_similar;
    logic [GAP_SUM_W-1:0] o_gap_total;
    logic [COL_SUM_W-1:0] o_conserved_total;
    logic [COL_SUM_W-1:0] o_similar_total;
    logic                 o_last;

    t_column_result pending_columns[$];
    int             mismatches = 0;
    int             cycles = 0;
    int             ready_hold = 0;
    bit             no_idle = 1'b0;
    string          amino_letters = "ACDEFGHIKLMNPQRSTVWY";

    t_residue             col_lead;
    t_residue             col_lead_group;
    logic                 col_open;
    logic                 col_same;
    logic                 col_alike;
    logic [COL_GAP_W-1:0] col_gaps;
    logic [GAP_SUM_W-1:0] run_gaps;
    logic [COL_SUM_W-1:0] run_conserved;
    logic [COL_SUM_W-1:0] run_similar;

    alignment_column_stats dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_residue          (i_residue),
        .i_column_end       (i_column_end),
        .i_alignment_end    (i_alignment_end),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_column_gap_count (o_column_gap_count),
        .o_column_conserved (o_column_conserved),
        .o_column_similar   (o_column_similar),
        .o_gap_total        (o_gap_total),
        .o_conserved_total  (o_conserved_total),
        .o_similar_total    (o_similar_total),
        .o_last             (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_residue amino_group(input t_residue r);
        case (r)
            t_residue'("A"), t_residue'("G"), t_residue'("I"),
            t_residue'("L"), t_residue'("M"), t_residue'("V"): return t_residue'("V");
            t_residue'("S"), t_residue'("T"):                  return t_residue'("T");
            t_residue'("D"), t_residue'("E"):                  return t_residue'("E");
            t_residue'("H"), t_residue'("K"), t_residue'("R"): return t_residue'("R");
            t_residue'("N"), t_residue'("Q"):                  return t_residue'("N");
            t_residue'("F"), t_residue'("Y"):                  return t_residue'("Y");
            default:                                           return r;
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_residue random_residue();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return t_residue'(amino_letters[$urandom_range(0, 19)]);
        end else if (roll < 75) begin
            return $urandom_range(0, 1) ? GAP_CODE : DASH_CODE;
        end
        return t_residue'($urandom_range(0, 127));
    endfunction

    function automatic t_residue residue_for_style(input t_column_style style,
                                                   input t_residue lead);
        t_residue pick;
        case (style)
            COL_CONSERVED: begin
                pick = ($urandom_range(0, 9) == 0) ? random_residue() : lead;
            end
            COL_SIMILAR: begin
                pick = lead;
                for (int n = 0; n < 20; n++) begin
                    pick = t_residue'(amino_letters[$urandom_range(0, 19)]);
                    if (amino_group(pick) == amino_group(lead)) break;
                    pick = lead;
                end
            end
            COL_GAPPY: begin
                pick = ($urandom_range(0, 3) != 0) ? GAP_CODE : random_residue();
                if (pick == GAP_CODE && $urandom_range(0, 1)) pick = DASH_CODE;
            end
            default: pick = random_residue();
        endcase
        return pick;
    endfunction

    task automatic clear_column_state();
        col_open  = 1'b1;
        col_lead  = '0;
        col_lead_group = '0;
        col_same  = 1'b1;
        col_alike = 1'b1;
        col_gaps  = '0;
    endtask

    task automatic clear_alignment_state();
        clear_column_state();
        run_gaps      = '0;
        run_conserved = '0;
        run_similar   = '0;
    endtask

    // Advances the column state by one accepted word and queues the column
    // figures when the word closes a column.
    task automatic update_column_stats(input t_residue raw, input logic ce,
                                       input logic ae);
        t_residue       r;
        t_residue       grp;
        logic           lead_real;
        t_column_result res;
        r = (raw == DASH_CODE) ? GAP_CODE : raw;
        grp = amino_group(r);
        if (col_open) begin
            col_lead       = r;
            col_lead_group = grp;
            col_same       = 1'b1;
            col_alike      = 1'b1;
            col_open       = 1'b0;
        end else begin
            if (r != col_lead) col_same = 1'b0;
            if (grp != col_lead_group) col_alike = 1'b0;
        end
        if (r == GAP_CODE) begin
            if (col_gaps != COL_GAP_MAX) col_gaps = col_gaps + 1'b1;
            if (run_gaps != GAP_SUM_MAX) run_gaps = run_gaps + 1'b1;
        end
        if (ce || ae) begin
            lead_real     = (col_lead != GAP_CODE);
            res.conserved = lead_real && col_same;
            res.similar   = lead_real && col_alike;
            if (res.conserved && run_conserved != COL_SUM_MAX) begin
                run_conserved = run_conserved + 1'b1;
            end
            if (res.similar && run_similar != COL_SUM_MAX) begin
                run_similar = run_similar + 1'b1;
            end
            res.gap_count       = col_gaps;
            res.gap_total       = run_gaps;
            res.conserved_total = run_conserved;
            res.similar_total   = run_similar;
            res.last            = ae;
            pending_columns.push_back(res);
            if (ae) begin
                clear_alignment_state();
            end else begin
                clear_column_state();
            end
        end
    endtask

    // Called at a rising edge; returns at the edge that accepts the word.
    task automatic send_residue(input t_residue r, input logic ce, input logic ae);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_residue       <= r;
        i_column_end    <= ce;
        i_alignment_end <= ae;
        do @(posedge i_clk); while (!o_ready);
        update_column_stats(r, ce, ae);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_columns.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (no_idle) begin
            i_ready    <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            i_ready    <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            ready_hold = pick_gap();
            i_ready <= (ready_hold == 0);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_column_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_columns.size() == 0) begin
                $error("result word with no column pending");
                mismatches++;
            end else begin
                want = pending_columns.pop_front();
                check_field("column_gap_count", 32'(want.gap_count),
                            32'(o_column_gap_count));
                check_field("column_conserved", 32'(want.conserved),
                            32'(o_column_conserved));
                check_field("column_similar", 32'(want.similar),
                            32'(o_column_similar));
                check_field("gap_total", 32'(want.gap_total), 32'(o_gap_total));
                check_field("conserved_total", 32'(want.conserved_total),
                            32'(o_conserved_total));
                check_field("similar_total", 32'(want.similar_total),
                            32'(o_similar_total));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("alignment_column_stats_tb: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        send_residue(7'd0, 1'b1, 1'b0);
        send_residue(7'd127, 1'b1, 1'b0);
        send_residue(GAP_CODE, 1'b0, 1'b0);
        send_residue(GAP_CODE, 1'b0, 1'b0);
        send_residue(DASH_CODE, 1'b1, 1'b0);
        send_residue(DASH_CODE, 1'b0, 1'b0);
        send_residue(t_residue'("A"), 1'b1, 1'b0);
        send_residue(t_residue'("W"), 1'b0, 1'b0);
        send_residue(t_residue'("W"), 1'b0, 1'b0);
        send_residue(t_residue'("W"), 1'b1, 1'b0);
        send_residue(t_residue'("I"), 1'b0, 1'b0);
        send_residue(t_residue'("L"), 1'b0, 1'b0);
        send_residue(t_residue'("V"), 1'b1, 1'b0);
        send_residue(t_residue'("K"), 1'b0, 1'b0);
        send_residue(t_residue'("H"), 1'b0, 1'b0);
        send_residue(t_residue'("R"), 1'b0, 1'b0);
        send_residue(t_residue'("D"), 1'b1, 1'b0);
        send_residue(t_residue'("A"), 1'b0, 1'b0);
        send_residue(DASH_CODE, 1'b0, 1'b0);
        send_residue(GAP_CODE, 1'b1, 1'b0);
        send_residue(t_residue'("S"), 1'b0, 1'b0);
        send_residue(t_residue'("T"), 1'b0, 1'b1);
        send_residue(t_residue'("Q"), 1'b1, 1'b1);
    endtask

    task automatic test_random_alignments();
        int            sent;
        int            nseq;
        int            ncol;
        bit            paused;
        t_column_style style;
        t_residue      lead;
        t_residue      r;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_WORDS) begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_residue(t_residue'($urandom_range(0, 127)),
                                 $urandom_range(0, 2) == 0, $urandom_range(0, 9) == 0);
                    sent++;
                end
            end else begin
                nseq = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8)
                                                  : $urandom_range(9, 40);
                ncol = $urandom_range(1, 6);
                for (int c = 0; c < ncol; c++) begin
                    style = t_column_style'($urandom_range(0, 3));
                    lead  = random_residue();
                    for (int s = 0; s < nseq; s++) begin
                        r = (s == 0) ? lead : residue_for_style(style, lead);
                        send_residue(r, s == nseq - 1, (s == nseq - 1) && (c == ncol - 1));
                        sent++;
                    end
                end
            end
            if (!paused && sent > RANDOM_WORDS / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        clear_alignment_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_alignments();
        i_valid <= 1'b0;
        while (pending_columns.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("alignment_column_stats_tb: done, clean");
        end else begin
            $display("alignment_column_stats_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: alignment_column_stats.f
rtl/acs_pkg.sv
rtl/alignment_column_stats.sv
rtl/acs_checker.sv
sim/alignment_column_stats_tb.sv
